// ===== hw/rtl/fpalu_pkg.sv =====
// Fixed-point ALU package: word width, opcodes, payload and pipeline types.
// No dependencies.
`default_nettype none

package fpalu_pkg;

   localparam int WORD_BITS = 32;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_MIN = 3'd4,
      OP_MAX = 3'd5,
      OP_INC = 3'd6,
      OP_DEC = 3'd7
   } opcode_type;

   typedef struct packed {
      opcode_type                    opcode;
      logic signed [WORD_BITS-1:0]   operand_a;
      logic signed [WORD_BITS-1:0]   operand_b;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0]   result;
      logic                          less;
      logic                          equal;
      logic                          greater;
      logic                          overflow;
      logic                          divide_by_zero;
   } rsp_word_type;

   // per-word control carried alongside the cell chain
   typedef struct packed {
      logic                  is_mul;
      logic                  is_div;
      logic                  sgn;
      logic                  less;
      logic                  equal;
      logic                  greater;
      logic                  ovf;
      logic                  dz;
      logic [WORD_BITS-1:0]  simple;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_point_alu_top.sv =====
// Fixed-point ALU top: input skid word, front stage, chain of bit cells, back end.
// Depends on fpalu_pkg, fpalu_prep, fpalu_cell, fpalu_fin.
//
//   channel | ports                                  | carries
//   req     | req_valid, req_ready, req_word         | opcode, operand_a, operand_b
//   rsp     | rsp_valid, rsp_ready, rsp_word         | result, less/equal/greater,
//           |                                        | overflow, divide_by_zero
//
// One word per cycle while the rsp word is not stalled.
// The pipe depth is set by the cell chain: one product or quotient bit per cell.
// Reset clears the stage valid bits and the skid valid bit only.
// A stalled rsp word freezes the whole pipe; the one-word input skid keeps
// req_ready registered and takes one more word during a stall.
`default_nettype none

module fixed_point_alu_top #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire fpalu_pkg::req_word_type  req_word,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output fpalu_pkg::rsp_word_type       rsp_word
);

   localparam int W = fpalu_pkg::WORD_BITS;
   localparam int N = W + FRAC_BITS;
   localparam int D = N + 3;

   logic                    adv;
   logic                    skid_valid_ff;
   logic                    skid_valid_in;
   fpalu_pkg::req_word_type skid_ff;
   logic                    ent_valid;
   fpalu_pkg::req_word_type ent_word;
   logic [D-1:0]            valid_ff;
   logic [D-1:0]            valid_in;

   fpalu_pkg::ctrl_type     chain_ctrl [0:N];
   logic [W-1:0]            chain_opd  [0:N];
   logic [N-1:0]            chain_sh   [0:N];
   logic [2*W-1:0]          chain_acc  [0:N];

   assign adv       = !valid_ff[D-1] || rsp_ready;
   assign req_ready = !skid_valid_ff;
   assign rsp_valid = valid_ff[D-1];
   assign ent_valid = skid_valid_ff || req_valid;
   assign ent_word  = skid_valid_ff ? skid_ff : req_word;
   assign valid_in  = {valid_ff[D-2:0], ent_valid};

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (adv) begin
         skid_valid_in = 1'b0;
      end else if (req_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (adv) begin
            valid_ff <= valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_valid && !skid_valid_ff) begin
         skid_ff <= req_word;
      end
   end

   fpalu_prep #(
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock   (clock),
      .adv     (adv),
      .word    (ent_word),
      .ctrl_ff (chain_ctrl[0]),
      .opd_ff  (chain_opd[0]),
      .sh_ff   (chain_sh[0]),
      .acc_ff  (chain_acc[0])
   );

   for (genvar k = 0; k < N; k++) begin : g_cell
      fpalu_cell #(
         .SH_BITS (N)
      ) u_cell (
         .clock   (clock),
         .adv     (adv),
         .up_ctrl (chain_ctrl[k]),
         .up_opd  (chain_opd[k]),
         .up_sh   (chain_sh[k]),
         .up_acc  (chain_acc[k]),
         .ctrl_ff (chain_ctrl[k+1]),
         .opd_ff  (chain_opd[k+1]),
         .sh_ff   (chain_sh[k+1]),
         .acc_ff  (chain_acc[k+1])
      );
   end

   fpalu_fin #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fin (
      .clock   (clock),
      .adv     (adv),
      .up_ctrl (chain_ctrl[N]),
      .up_opd  (chain_opd[N]),
      .up_sh   (chain_sh[N]),
      .up_acc  (chain_acc[N]),
      .rsp_ff  (rsp_word)
   );

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(!adv))
      else $error("skid loaded without a stall");

   a_pipe_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(valid_ff))
      else $error("pipe moved during a stall");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_word.less, rsp_word.equal, rsp_word.greater}))
      else $error("compare flags not one-hot");

   a_dz_no_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.overflow && rsp_word.divide_by_zero))
      else $error("divide by zero with overflow");

   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.overflow |->
         rsp_word.result == fpalu_pkg::WORD_MAX || rsp_word.result == fpalu_pkg::WORD_MIN)
      else $error("overflow without a limit value");

endmodule

`default_nettype wire

// ===== hw/rtl/fpalu_prep.sv =====
// Front stage: compare flags, saturating add/sub/inc/dec, min/max, divide by zero,
// and magnitudes that seed the cell chain. Depends on fpalu_pkg.
`default_nettype none

module fpalu_prep #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   adv,
   input  wire fpalu_pkg::req_word_type                word,
   output fpalu_pkg::ctrl_type                         ctrl_ff,
   output logic [fpalu_pkg::WORD_BITS-1:0]             opd_ff,
   output logic [fpalu_pkg::WORD_BITS+FRAC_BITS-1:0]   sh_ff,
   output logic [2*fpalu_pkg::WORD_BITS-1:0]           acc_ff
);

   localparam int W = fpalu_pkg::WORD_BITS;
   localparam int N = W + FRAC_BITS;

   logic signed [W-1:0] a;
   logic signed [W-1:0] b;
   logic signed [W:0]   ea;
   logic signed [W:0]   addend;
   logic                cin;
   logic signed [W:0]   sum;
   logic [W-1:0]        sat;
   logic                sat_ovf;
   logic                na;
   logic                nb;
   logic [W-1:0]        ma;
   logic [W-1:0]        mb;
   logic                lt;
   logic                gt;
   logic                b_zero;
   fpalu_pkg::ctrl_type ctrl_in;
   logic [W-1:0]        opd_in;
   logic [N-1:0]        sh_in;

   assign a = word.operand_a;
   assign b = word.operand_b;
   assign na = a[W-1];
   assign nb = b[W-1];
   assign ma = na ? W'(-a) : W'(a);
   assign mb = nb ? W'(-b) : W'(b);
   assign lt = $signed(a) < $signed(b);
   assign gt = $signed(a) > $signed(b);
   assign b_zero = (b == '0);
   assign ea = {a[W-1], a};

   always_comb begin
      addend = {b[W-1], b};
      cin = 1'b0;
      case (word.opcode)
         fpalu_pkg::OP_SUB: begin
            addend = ~{b[W-1], b};
            cin = 1'b1;
         end
         fpalu_pkg::OP_INC: begin
            addend = (W+1)'(1);
         end
         fpalu_pkg::OP_DEC: begin
            addend = '1;
         end
         default: begin
            addend = {b[W-1], b};
         end
      endcase
   end

   assign sum = ea + addend + (W+1)'(cin);
   assign sat_ovf = sum[W] != sum[W-1];
   assign sat = sat_ovf ? (sum[W] ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX) : sum[W-1:0];

   always_comb begin
      ctrl_in.is_mul  = 1'b0;
      ctrl_in.is_div  = 1'b0;
      ctrl_in.sgn     = na ^ nb;
      ctrl_in.less    = lt;
      ctrl_in.equal   = !lt && !gt;
      ctrl_in.greater = gt;
      ctrl_in.ovf     = 1'b0;
      ctrl_in.dz      = 1'b0;
      ctrl_in.simple  = sat;
      case (word.opcode)
         fpalu_pkg::OP_MUL: begin
            ctrl_in.is_mul = 1'b1;
         end
         fpalu_pkg::OP_DIV: begin
            ctrl_in.is_div = !b_zero;
            ctrl_in.dz     = b_zero;
            if (a == '0) begin
               ctrl_in.simple = '0;
            end else begin
               ctrl_in.simple = na ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX;
            end
         end
         fpalu_pkg::OP_MIN: begin
            ctrl_in.simple = lt ? a : b;
         end
         fpalu_pkg::OP_MAX: begin
            ctrl_in.simple = gt ? a : b;
         end
         default: begin
            ctrl_in.ovf = sat_ovf;
         end
      endcase
   end

   assign opd_in = (word.opcode == fpalu_pkg::OP_DIV) ? mb : ma;
   assign sh_in  = (word.opcode == fpalu_pkg::OP_DIV) ? (N'(ma) << FRAC_BITS) : N'(mb);

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff <= ctrl_in;
         opd_ff  <= opd_in;
         sh_ff   <= sh_in;
         acc_ff  <= '0;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fpalu_cell.sv =====
// One chain cell: one shift-add product step or one restoring quotient step.
// Depends on fpalu_pkg.
`default_nettype none

module fpalu_cell #(
   parameter int SH_BITS = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 adv,
   input  wire fpalu_pkg::ctrl_type                  up_ctrl,
   input  wire logic [fpalu_pkg::WORD_BITS-1:0]      up_opd,
   input  wire logic [SH_BITS-1:0]                   up_sh,
   input  wire logic [2*fpalu_pkg::WORD_BITS-1:0]    up_acc,
   output fpalu_pkg::ctrl_type                       ctrl_ff,
   output logic [fpalu_pkg::WORD_BITS-1:0]           opd_ff,
   output logic [SH_BITS-1:0]                        sh_ff,
   output logic [2*fpalu_pkg::WORD_BITS-1:0]         acc_ff
);

   localparam int W = fpalu_pkg::WORD_BITS;

   logic             top_bit;
   logic [W:0]       r2;
   logic [W:0]       diff;
   logic             ge;
   logic [SH_BITS-1:0] sh_in;
   logic [2*W-1:0]   acc_in;

   assign top_bit = up_sh[SH_BITS-1];
   assign r2      = {up_acc[W-1:0], top_bit};
   assign ge      = r2 >= {1'b0, up_opd};
   assign diff    = r2 - {1'b0, up_opd};

   always_comb begin
      if (up_ctrl.is_div) begin
         acc_in = (2*W)'(ge ? diff[W-1:0] : r2[W-1:0]);
         sh_in  = {up_sh[SH_BITS-2:0], ge};
      end else begin
         acc_in = {up_acc[2*W-2:0], 1'b0} + (top_bit ? (2*W)'(up_opd) : '0);
         sh_in  = {up_sh[SH_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff <= up_ctrl;
         opd_ff  <= up_opd;
         sh_ff   <= sh_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fpalu_fin.sv =====
// Back end: rounding stage, then saturation, sign and result select into the
// output register. Depends on fpalu_pkg.
`default_nettype none

module fpalu_fin #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   adv,
   input  wire fpalu_pkg::ctrl_type                    up_ctrl,
   input  wire logic [fpalu_pkg::WORD_BITS-1:0]        up_opd,
   input  wire logic [fpalu_pkg::WORD_BITS+FRAC_BITS-1:0] up_sh,
   input  wire logic [2*fpalu_pkg::WORD_BITS-1:0]      up_acc,
   output fpalu_pkg::rsp_word_type                     rsp_ff
);

   localparam int W = fpalu_pkg::WORD_BITS;
   localparam logic [2*W-1:0] HALF = ((2*W)'(1) << FRAC_BITS) >> 1;

   logic [2*W-1:0]          mul_mag;
   logic                    round_up;
   logic [2*W-1:0]          div_mag;
   logic [2*W-1:0]          mag_in;
   logic [2*W-1:0]          mag_ff;
   fpalu_pkg::ctrl_type     ctrl_ff;

   logic                    neg;
   logic [2*W-1:0]          lim;
   logic                    clamp;
   logic [W-1:0]            arith_res;
   fpalu_pkg::rsp_word_type rsp_in;

   assign mul_mag  = (up_acc + HALF) >> FRAC_BITS;
   assign round_up = {up_acc[W-1:0], 1'b0} >= {1'b0, up_opd};
   assign div_mag  = (2*W)'(up_sh) + (2*W)'(round_up);
   assign mag_in   = up_ctrl.is_mul ? mul_mag : div_mag;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff  <= mag_in;
         ctrl_ff <= up_ctrl;
      end
   end

   assign neg   = (mag_ff != '0) && ctrl_ff.sgn;
   assign lim   = (2*W)'(fpalu_pkg::WORD_MAX) + (2*W)'(neg);
   assign clamp = mag_ff > lim;

   always_comb begin
      if (clamp) begin
         arith_res = neg ? fpalu_pkg::WORD_MIN : fpalu_pkg::WORD_MAX;
      end else if (neg) begin
         arith_res = W'(-mag_ff[W-1:0]);
      end else begin
         arith_res = mag_ff[W-1:0];
      end
   end

   always_comb begin
      rsp_in.less           = ctrl_ff.less;
      rsp_in.equal          = ctrl_ff.equal;
      rsp_in.greater        = ctrl_ff.greater;
      rsp_in.divide_by_zero = ctrl_ff.dz;
      if (ctrl_ff.is_mul || ctrl_ff.is_div) begin
         rsp_in.result   = arith_res;
         rsp_in.overflow = clamp;
      end else begin
         rsp_in.result   = ctrl_ff.simple;
         rsp_in.overflow = ctrl_ff.ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
